// ===== rtl/ssr_pkg.sv =====
package ssr_pkg;

    localparam int NUM_SETS      = 2048;
    localparam int NUM_WAYS      = 16;
    localparam int PRED_ENTRIES  = 1024;
    localparam int RRPV_MAX      = 3;
    localparam int COUNTER_MAX   = 3;
    localparam int SIG_SHIFT     = 6;
    localparam int VALID_BITS    = 16;

    localparam int SET_IN_W      = 11;
    localparam int WAY_IN_W      = 5;
    localparam int ADDR_W        = 64;
    localparam int THR_W         = 2;
    localparam int VICTIM_W      = 4;

    localparam int SET_W         = $clog2(NUM_SETS);
    localparam int WAY_W         = $clog2(NUM_WAYS);
    localparam int SIG_W         = $clog2(PRED_ENTRIES);
    localparam int RRPV_W        = $clog2(RRPV_MAX + 1);
    localparam int CNT_W         = $clog2(COUNTER_MAX + 1);
    localparam int CMP_W         = THR_W + CNT_W;

    localparam int CLR_DEPTH     = (NUM_SETS > PRED_ENTRIES) ? NUM_SETS : PRED_ENTRIES;
    localparam int CLR_W         = $clog2(CLR_DEPTH);

    localparam int CMDQ_DEPTH    = 2;
    localparam int CMDQ_PTR_W    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W    = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH    = 2;
    localparam int RESQ_PTR_W    = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W    = $clog2(RESQ_DEPTH + 1);

    localparam logic [THR_W-1:0] HOT_THRESHOLD_RESET = THR_W'(2);

    typedef enum logic [1:0] {
        KIND_QUERY,
        KIND_HIT,
        KIND_FILL
    } t_kind;

    typedef struct packed {
        t_kind                  kind;
        logic [SET_W-1:0]       set_idx;
        logic [WAY_W-1:0]       way;
        logic [SIG_W-1:0]       new_sig;
        logic [VALID_BITS-1:0]  valid;
    } t_cmd;

    typedef logic [NUM_WAYS-1:0][RRPV_W-1:0] t_rrpv_row;
    typedef logic [NUM_WAYS-1:0][SIG_W-1:0]  t_sig_row;

endpackage

// ===== rtl/ssr_front.sv =====
module ssr_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic                            i_action,
    input  logic [ssr_pkg::SET_IN_W-1:0]    i_set_index,
    input  logic [ssr_pkg::WAY_IN_W-1:0]    i_way_index,
    input  logic                            i_is_hit,
    input  logic [ssr_pkg::ADDR_W-1:0]      i_program_counter,
    input  logic [ssr_pkg::ADDR_W-1:0]      i_phys_addr,
    input  logic [ssr_pkg::VALID_BITS-1:0]  i_valid_ways,
    input  logic                            i_clearing,
    output logic                            o_cmd_valid,
    output ssr_pkg::t_cmd                   o_cmd,
    input  logic                            i_cmd_pop
);

    ssr_pkg::t_cmd                      r_q [ssr_pkg::CMDQ_DEPTH];
    logic [ssr_pkg::CMDQ_PTR_W-1:0]     r_wr_ptr;
    logic [ssr_pkg::CMDQ_PTR_W-1:0]     r_rd_ptr;
    logic [ssr_pkg::CMDQ_CNT_W-1:0]     r_count;
    logic [ssr_pkg::CMDQ_CNT_W-1:0]     n_count;

    ssr_pkg::t_cmd  cmd;
    logic           bypass;
    logic           wr;
    logic           rd;

    // classify the incoming beat
    always_comb begin
        cmd         = '0;
        cmd.set_idx = i_set_index[ssr_pkg::SET_W-1:0];
        cmd.way     = i_way_index[ssr_pkg::WAY_W-1:0];
        cmd.new_sig = i_program_counter[ssr_pkg::SIG_W-1:0]
                    ^ i_phys_addr[ssr_pkg::SIG_SHIFT +: ssr_pkg::SIG_W];
        cmd.valid   = i_valid_ways;
        if (!i_action) begin
            cmd.kind = ssr_pkg::KIND_QUERY;
        end else if (i_is_hit) begin
            cmd.kind = ssr_pkg::KIND_HIT;
        end else begin
            cmd.kind = ssr_pkg::KIND_FILL;
        end
    end

    assign bypass      = i_action && (i_way_index >= ssr_pkg::WAY_IN_W'(ssr_pkg::NUM_WAYS));
    assign o_full      = i_clearing || (r_count == ssr_pkg::CMDQ_CNT_W'(ssr_pkg::CMDQ_DEPTH));
    assign wr          = i_push && !o_full && !bypass;
    assign rd          = i_cmd_pop && (r_count != '0);
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_count = r_count + ssr_pkg::CMDQ_CNT_W'(wr) - ssr_pkg::CMDQ_CNT_W'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> (r_count != '0))
        else $error("command popped from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ssr_pkg::CMDQ_CNT_W'(ssr_pkg::CMDQ_DEPTH))
        else $error("command queue overflow");

    a_stored_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr |=> (r_count != '0))
        else $error("accepted beat not queued");

    a_closed_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clearing |-> (o_full && (r_count == '0)))
        else $error("beat taken during clearing pass");

endmodule

// ===== rtl/ssr_back.sv =====
module ssr_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [ssr_pkg::THR_W-1:0]       i_hot_threshold,
    input  logic                            i_cmd_valid,
    input  ssr_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    output logic                            o_clearing,
    output logic                            o_res_empty,
    input  logic                            i_res_pop,
    output logic [ssr_pkg::VICTIM_W-1:0]    o_victim_way
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COUNT,
        ST_WRITE
    } t_state;

    t_state                             r_state;
    ssr_pkg::t_cmd                      r_op;
    logic [ssr_pkg::CLR_W-1:0]          r_clr_idx;

    ssr_pkg::t_rrpv_row                 r_rrpv_mem [ssr_pkg::NUM_SETS];
    ssr_pkg::t_sig_row                  r_sig_mem  [ssr_pkg::NUM_SETS];
    logic [ssr_pkg::CNT_W-1:0]          r_pred_mem [ssr_pkg::PRED_ENTRIES];

    ssr_pkg::t_rrpv_row                 r_rrpv_rd;
    ssr_pkg::t_sig_row                  r_sig_rd;
    logic [ssr_pkg::CNT_W-1:0]          r_pred_rd;
    logic [ssr_pkg::CNT_W-1:0]          r_new_cnt;

    logic [ssr_pkg::VICTIM_W-1:0]       r_res_q [ssr_pkg::RESQ_DEPTH];
    logic [ssr_pkg::RESQ_PTR_W-1:0]     r_res_wr;
    logic [ssr_pkg::RESQ_PTR_W-1:0]     r_res_rd;
    logic [ssr_pkg::RESQ_CNT_W-1:0]     r_res_cnt;
    logic [ssr_pkg::RESQ_CNT_W-1:0]     n_res_cnt;

    logic [ssr_pkg::SIG_W-1:0]          old_sig;
    logic [ssr_pkg::SIG_W-1:0]          pred_rd_addr;
    logic [ssr_pkg::RRPV_MAX:0]         present;
    logic [ssr_pkg::RRPV_W-1:0]         top;
    logic [ssr_pkg::RRPV_W-1:0]         age_add;
    logic                               all_valid;
    logic [ssr_pkg::WAY_W-1:0]          victim;
    ssr_pkg::t_rrpv_row                 aged_row;
    ssr_pkg::t_rrpv_row                 new_rrpv_row;
    ssr_pkg::t_sig_row                  new_sig_row;
    ssr_pkg::t_rrpv_row                 clr_rrpv_row;
    logic [ssr_pkg::CNT_W-1:0]          cnt_inc;
    logic [ssr_pkg::CNT_W-1:0]          cnt_dec;
    logic [ssr_pkg::CNT_W-1:0]          eff_new;
    logic [ssr_pkg::RRPV_W-1:0]         ins_rrpv;

    logic                               row_we;
    logic [ssr_pkg::SET_W-1:0]          row_addr;
    ssr_pkg::t_rrpv_row                 row_rrpv_wd;
    ssr_pkg::t_sig_row                  row_sig_wd;
    logic                               pred_we;
    logic [ssr_pkg::SIG_W-1:0]          pred_addr;
    logic [ssr_pkg::CNT_W-1:0]          pred_wd;
    logic                               clr_rows;
    logic                               clr_pred;

    logic                               res_push;
    logic                               res_pop;
    logic                               can_start;
    logic                               is_update;

    assign old_sig      = r_sig_rd[r_op.way];
    assign pred_rd_addr = (r_state == ST_COUNT) ? old_sig : r_op.new_sig;
    assign is_update    = (r_op.kind != ssr_pkg::KIND_QUERY);

    // victim search and set ageing
    always_comb begin
        present = '0;
        for (int v = 0; v <= ssr_pkg::RRPV_MAX; v++) begin
            for (int w = 0; w < ssr_pkg::NUM_WAYS; w++) begin
                if (r_rrpv_rd[w] == ssr_pkg::RRPV_W'(v)) begin
                    present[v] = 1'b1;
                end
            end
        end
        top = '0;
        for (int v = 0; v <= ssr_pkg::RRPV_MAX; v++) begin
            if (present[v]) begin
                top = ssr_pkg::RRPV_W'(v);
            end
        end
        age_add = ssr_pkg::RRPV_W'(ssr_pkg::RRPV_MAX) - top;
        for (int w = 0; w < ssr_pkg::NUM_WAYS; w++) begin
            aged_row[w] = r_rrpv_rd[w] + age_add;
        end

        all_valid = 1'b1;
        victim    = '0;
        for (int w = ssr_pkg::NUM_WAYS - 1; w >= 0; w--) begin
            if (r_rrpv_rd[w] == top) begin
                victim = ssr_pkg::WAY_W'(w);
            end
        end
        for (int w = ssr_pkg::NUM_WAYS - 1; w >= 0; w--) begin
            if ((w < ssr_pkg::VALID_BITS) && !r_op.valid[w]) begin
                victim    = ssr_pkg::WAY_W'(w);
                all_valid = 1'b0;
            end
        end
    end

    // predictor counter update and insertion position
    always_comb begin
        cnt_inc = (r_pred_rd == ssr_pkg::CNT_W'(ssr_pkg::COUNTER_MAX)) ? r_pred_rd
                                                                       : r_pred_rd + 1'b1;
        cnt_dec = (r_pred_rd == '0) ? r_pred_rd : r_pred_rd - 1'b1;
        eff_new = (old_sig == r_op.new_sig) ? cnt_dec : r_new_cnt;
        if (ssr_pkg::CMP_W'(eff_new) >= ssr_pkg::CMP_W'(i_hot_threshold)) begin
            ins_rrpv = '0;
        end else begin
            ins_rrpv = ssr_pkg::RRPV_W'(ssr_pkg::RRPV_MAX - 1);
        end
    end

    always_comb begin
        new_rrpv_row = r_rrpv_rd;
        new_sig_row  = r_sig_rd;
        case (r_op.kind)
            ssr_pkg::KIND_QUERY: begin
                if (all_valid) begin
                    new_rrpv_row = aged_row;
                end
            end
            ssr_pkg::KIND_HIT: begin
                new_rrpv_row[r_op.way] = '0;
            end
            ssr_pkg::KIND_FILL: begin
                new_rrpv_row[r_op.way] = ins_rrpv;
                new_sig_row[r_op.way]  = r_op.new_sig;
            end
            default: begin
                new_rrpv_row = r_rrpv_rd;
            end
        endcase
        for (int w = 0; w < ssr_pkg::NUM_WAYS; w++) begin
            clr_rrpv_row[w] = ssr_pkg::RRPV_W'(ssr_pkg::RRPV_MAX);
        end
    end

    // memory write ports
    assign clr_rows = (r_state == ST_CLEAR)
                   && ({1'b0, r_clr_idx} < (ssr_pkg::CLR_W + 1)'(ssr_pkg::NUM_SETS));
    assign clr_pred = (r_state == ST_CLEAR)
                   && ({1'b0, r_clr_idx} < (ssr_pkg::CLR_W + 1)'(ssr_pkg::PRED_ENTRIES));

    always_comb begin
        if (r_state == ST_CLEAR) begin
            row_we      = clr_rows;
            row_addr    = r_clr_idx[ssr_pkg::SET_W-1:0];
            row_rrpv_wd = clr_rrpv_row;
            row_sig_wd  = '0;
            pred_we     = clr_pred;
            pred_addr   = r_clr_idx[ssr_pkg::SIG_W-1:0];
            pred_wd     = '0;
        end else begin
            row_we      = (r_state == ST_WRITE);
            row_addr    = r_op.set_idx;
            row_rrpv_wd = new_rrpv_row;
            row_sig_wd  = new_sig_row;
            pred_we     = (r_state == ST_WRITE) && is_update;
            pred_addr   = old_sig;
            pred_wd     = (r_op.kind == ssr_pkg::KIND_HIT) ? cnt_inc : cnt_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            r_rrpv_mem[row_addr] <= row_rrpv_wd;
            r_sig_mem[row_addr]  <= row_sig_wd;
        end
        r_rrpv_rd <= r_rrpv_mem[r_op.set_idx];
        r_sig_rd  <= r_sig_mem[r_op.set_idx];
    end

    always_ff @(posedge i_clk) begin
        if (pred_we) begin
            r_pred_mem[pred_addr] <= pred_wd;
        end
        r_pred_rd <= r_pred_mem[pred_rd_addr];
    end

    // result queue
    assign res_push     = (r_state == ST_WRITE) && !is_update;
    assign res_pop      = i_res_pop && (r_res_cnt != '0);
    assign n_res_cnt    = r_res_cnt + ssr_pkg::RESQ_CNT_W'(res_push)
                        - ssr_pkg::RESQ_CNT_W'(res_pop);
    assign o_res_empty  = (r_res_cnt == '0);
    assign o_victim_way = r_res_q[r_res_rd];

    always_ff @(posedge i_clk) begin
        if (res_push) begin
            r_res_q[r_res_wr] <= ssr_pkg::VICTIM_W'(victim);
        end
    end

    // sequencer
    assign can_start = i_cmd_valid
                    && ((i_cmd.kind != ssr_pkg::KIND_QUERY)
                        || (n_res_cnt < ssr_pkg::RESQ_CNT_W'(ssr_pkg::RESQ_DEPTH)));
    assign o_cmd_pop  = can_start && ((r_state == ST_IDLE) || (r_state == ST_WRITE));
    assign o_clearing = (r_state == ST_CLEAR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_idx <= '0;
            r_res_wr  <= '0;
            r_res_rd  <= '0;
            r_res_cnt <= '0;
        end else begin
            r_res_cnt <= n_res_cnt;
            if (res_push) begin
                r_res_wr <= r_res_wr + 1'b1;
            end
            if (res_pop) begin
                r_res_rd <= r_res_rd + 1'b1;
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                    if (r_clr_idx == ssr_pkg::CLR_W'(ssr_pkg::CLR_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (o_cmd_pop) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= is_update ? ST_COUNT : ST_WRITE;
                end
                ST_COUNT: begin
                    r_new_cnt <= r_pred_rd;
                    r_state   <= ST_WRITE;
                end
                ST_WRITE: begin
                    r_state <= o_cmd_pop ? ST_READ : ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_op <= i_cmd;
        end
    end

    a_res_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_cnt <= ssr_pkg::RESQ_CNT_W'(ssr_pkg::RESQ_DEPTH))
        else $error("result queue overflow");

    a_no_start_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_cmd_pop)
        else $error("command started during clearing pass");

    a_write_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |-> ($past(r_state) == ST_READ || $past(r_state) == ST_COUNT))
        else $error("row written without a read");

    a_count_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COUNT) |-> is_update)
        else $error("counter step taken for a query");

endmodule

// ===== rtl/ship_srrip_replacement.sv =====
// channel   direction  handshake          payload
// input     in         push / full        i_action, i_set_index, i_way_index, i_is_hit,
//                                         i_program_counter, i_phys_addr, i_valid_ways
// result    out        empty / pop        o_victim_way (victim queries only)
// config    in         i_cfg_wr_en        i_cfg_wr_data (hot threshold)
//
// one beat at a time in the back end: a victim query steps through read and write,
// a hit or fill update through read, count and write, for the row RMW and counter read
// bypass updates are dropped at the front and never reach the back end
// after reset a clearing pass over the 2048 set rows holds full high
// a 2-entry command queue and a 2-entry result queue let each side stall on its own
module ship_srrip_replacement (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_action,
    input  logic [ssr_pkg::SET_IN_W-1:0]    i_set_index,
    input  logic [ssr_pkg::WAY_IN_W-1:0]    i_way_index,
    input  logic                            i_is_hit,
    input  logic [ssr_pkg::ADDR_W-1:0]      i_program_counter,
    input  logic [ssr_pkg::ADDR_W-1:0]      i_phys_addr,
    input  logic [ssr_pkg::VALID_BITS-1:0]  i_valid_ways,
    output logic                            empty,
    input  logic                            pop,
    output logic [ssr_pkg::VICTIM_W-1:0]    o_victim_way,
    input  logic                            i_cfg_wr_en,
    input  logic [ssr_pkg::THR_W-1:0]       i_cfg_wr_data
);

    logic [ssr_pkg::THR_W-1:0]  r_hot_threshold;
    logic                       cmd_valid;
    ssr_pkg::t_cmd              cmd;
    logic                       cmd_pop;
    logic                       clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hot_threshold <= ssr_pkg::HOT_THRESHOLD_RESET;
        end else if (i_cfg_wr_en) begin
            r_hot_threshold <= i_cfg_wr_data;
        end
    end

    ssr_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .o_full            (full),
        .i_action          (i_action),
        .i_set_index       (i_set_index),
        .i_way_index       (i_way_index),
        .i_is_hit          (i_is_hit),
        .i_program_counter (i_program_counter),
        .i_phys_addr       (i_phys_addr),
        .i_valid_ways      (i_valid_ways),
        .i_clearing        (clearing),
        .o_cmd_valid       (cmd_valid),
        .o_cmd             (cmd),
        .i_cmd_pop         (cmd_pop)
    );

    ssr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_hot_threshold (r_hot_threshold),
        .i_cmd_valid     (cmd_valid),
        .i_cmd           (cmd),
        .o_cmd_pop       (cmd_pop),
        .o_clearing      (clearing),
        .o_res_empty     (empty),
        .i_res_pop       (pop),
        .o_victim_way    (o_victim_way)
    );

endmodule
